FILE: rtl/core/tsg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsg_pkg: shared types and constants for the terrain strip ground snap
// Holds the queued command type, the back-end state type and the fixed
// multiply-accumulate program that tests one strip triangle.
// ----------------------------------------------------------------------------
package tsg_pkg;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = 33;
  localparam int OPND_W  = 34;
  localparam int PROD_W  = 68;
  localparam int NRM_W   = 67;
  localparam int ACC_W   = 102;
  localparam int RAD_W   = 31;
  localparam int IDX_W   = 10;
  localparam int GRID_W  = 8;
  localparam int VTX_W   = 3 * COORD_W;
  localparam int HI_SHIFT = 33;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic REG_GRID_COLUMNS = 1'b0;
  localparam logic REG_GRID_ROWS    = 1'b1;

  localparam int NUM_OPS = 22;
  localparam int STEP_W  = 5;

  typedef struct packed {
    logic                       is_query;
    logic                       in_range;
    logic [IDX_W-1:0]           index;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  z;
    logic [RAD_W-1:0]           radius;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_READ, S_SETUP, S_MAC, S_NEXT, S_DIV, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_AX, OP_AY, OP_AZ, OP_R,
    OP_DX, OP_DY, OP_DZ,
    OP_E0X, OP_E0Y, OP_E0Z, OP_E1X, OP_E1Z, OP_E2X, OP_E2Z,
    OP_O1X, OP_O1Z, OP_O2X, OP_O2Z,
    OP_MX, OP_MY, OP_MZ,
    OP_NXL, OP_NXH, OP_NYL, OP_NYH, OP_NZL, OP_NZH
  } opnd_t;

  typedef enum logic [1:0] {ACC_CLR, ACC_ADD, ACC_SUB} acc_t;
  typedef enum logic [1:0] {CHK_NONE, CHK_GATE, CHK_EDGE, CHK_DOT} chk_t;
  typedef enum logic [2:0] {LAT_NONE, LAT_NX, LAT_NY, LAT_NZ, LAT_NUM} lat_t;

  typedef struct packed {
    opnd_t src_a;
    opnd_t src_b;
    acc_t  acc;
    logic  shift;
    chk_t  chk;
    lat_t  lat;
  } op_t;

  // One product per step; the accumulator folds it in on the following cycle.
  function automatic op_t op_rom(input logic [STEP_W-1:0] s);
    op_t o;
    o = '{OP_AX, OP_AX, ACC_CLR, 1'b0, CHK_NONE, LAT_NONE};
    unique case (s)
      5'd0:  o = '{OP_AX,  OP_AX,  ACC_CLR, 1'b0, CHK_NONE, LAT_NONE};
      5'd1:  o = '{OP_AY,  OP_AY,  ACC_ADD, 1'b0, CHK_NONE, LAT_NONE};
      5'd2:  o = '{OP_AZ,  OP_AZ,  ACC_ADD, 1'b0, CHK_NONE, LAT_NONE};
      5'd3:  o = '{OP_R,   OP_R,   ACC_SUB, 1'b0, CHK_GATE, LAT_NONE};
      5'd4:  o = '{OP_E0X, OP_DZ,  ACC_CLR, 1'b0, CHK_NONE, LAT_NONE};
      5'd5:  o = '{OP_DX,  OP_E0Z, ACC_SUB, 1'b0, CHK_EDGE, LAT_NONE};
      5'd6:  o = '{OP_E1X, OP_O1Z, ACC_CLR, 1'b0, CHK_NONE, LAT_NONE};
      5'd7:  o = '{OP_O1X, OP_E1Z, ACC_SUB, 1'b0, CHK_EDGE, LAT_NONE};
      5'd8:  o = '{OP_E2X, OP_O2Z, ACC_CLR, 1'b0, CHK_NONE, LAT_NONE};
      5'd9:  o = '{OP_O2X, OP_E2Z, ACC_SUB, 1'b0, CHK_EDGE, LAT_NONE};
      5'd10: o = '{OP_E0Y, OP_MZ,  ACC_CLR, 1'b0, CHK_NONE, LAT_NONE};
      5'd11: o = '{OP_E0Z, OP_MY,  ACC_SUB, 1'b0, CHK_NONE, LAT_NX};
      5'd12: o = '{OP_E0Z, OP_MX,  ACC_CLR, 1'b0, CHK_NONE, LAT_NONE};
      5'd13: o = '{OP_E0X, OP_MZ,  ACC_SUB, 1'b0, CHK_NONE, LAT_NY};
      5'd14: o = '{OP_E0X, OP_MY,  ACC_CLR, 1'b0, CHK_NONE, LAT_NONE};
      5'd15: o = '{OP_E0Y, OP_MX,  ACC_SUB, 1'b0, CHK_NONE, LAT_NZ};
      5'd16: o = '{OP_NXL, OP_DX,  ACC_CLR, 1'b0, CHK_NONE, LAT_NONE};
      5'd17: o = '{OP_NXH, OP_DX,  ACC_ADD, 1'b1, CHK_NONE, LAT_NONE};
      5'd18: o = '{OP_NZL, OP_DZ,  ACC_ADD, 1'b0, CHK_NONE, LAT_NONE};
      5'd19: o = '{OP_NZH, OP_DZ,  ACC_ADD, 1'b1, CHK_NONE, LAT_NUM};
      5'd20: o = '{OP_NYL, OP_DY,  ACC_ADD, 1'b0, CHK_NONE, LAT_NONE};
      5'd21: o = '{OP_NYH, OP_DY,  ACC_ADD, 1'b1, CHK_DOT,  LAT_NONE};
      default: o = '{OP_AX, OP_AX, ACC_CLR, 1'b0, CHK_NONE, LAT_NONE};
    endcase
    return o;
  endfunction

endpackage

FILE: rtl/core/terrain_strip_ground_snap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terrain_strip_ground_snap: ground height snap over a triangle-strip store
// Loads strip vertices and answers point-in-triangle ground queries.
// ----------------------------------------------------------------------------
// A load beat (mode 0) writes one Q16.16 vertex into the strip store and
// returns one beat with landed low and ground_y zero, straight from the idle
// state. A query beat (mode 1) walks triangles 0 .. count-1 in strip order,
// where count is 2*columns*rows + 4*rows - 4, clamped to the store depth
// minus two. Each examined triangle is tested serially, because the three
// vertices come through the store's single read port one at a time and every
// product goes through one shared 34x34 multiplier; a triangle whose first
// vertex is outside the radius box is dropped at the first step. The first
// triangle that holds the point in XZ, within the search radius of its first
// vertex, with the point below its plane finishes the walk with a serial
// division for the height; a miss returns the query's own y with landed low.
// A two-entry command queue in front lets new beats arrive while the walker is
// busy, and the result register lets the walker move on while a result beat
// waits. The store has no reset; a query must only touch entries that were
// loaded. Grid registers are written through cfg_write / cfg_index / cfg_data
// while no beat is in flight; the user must ensure it, the block does not.
// ----------------------------------------------------------------------------
module terrain_strip_ground_snap
  import tsg_pkg::*;
#(
  parameter int STRIP_DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic                       cfg_index,
  input  logic [GRID_W-1:0]          cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       mode,
  input  logic [IDX_W-1:0]           entry_index,
  input  logic signed [COORD_W-1:0]  coord_x,
  input  logic signed [COORD_W-1:0]  coord_y,
  input  logic signed [COORD_W-1:0]  coord_z,
  input  logic [RAD_W-1:0]           search_radius,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       landed,
  output logic signed [COORD_W-1:0]  ground_y
);

  logic [GRID_W-1:0] grid_columns;
  logic [GRID_W-1:0] grid_rows;
  logic              cmd_valid;
  cmd_t              cmd;
  logic              cmd_pop;

  // Grid size registers; both come out of reset as a single cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= GRID_W'(1);
      grid_rows    <= GRID_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GRID_COLUMNS: grid_columns <= cfg_data;
        REG_GRID_ROWS:    grid_rows    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The front end tags and queues beats; the back end owns the store.
  tsg_front #(
    .STRIP_DEPTH(STRIP_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .entry_index  (entry_index),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .coord_z      (coord_z),
    .search_radius(search_radius),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  tsg_back #(
    .STRIP_DEPTH(STRIP_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .grid_columns(grid_columns),
    .grid_rows   (grid_rows),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .landed      (landed),
    .ground_y    (ground_y)
  );

endmodule

FILE: rtl/core/tsg_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsg_ram: generic single-write, single-read memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module tsg_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/tsg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsg_div: signed restoring divider, one quotient bit per cycle
// Quotient is truncated toward zero and is registered in the cycle after the last bit.
// ----------------------------------------------------------------------------
module tsg_div
  import tsg_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [ACC_W-1:0]  num,
  input  logic signed [NRM_W-1:0]  den,
  output logic                     done,
  output logic signed [ACC_W-1:0]  quot
);

  localparam int CNT_W = $clog2(ACC_W);

  logic             busy;
  logic             fin;
  logic [CNT_W-1:0] cnt;
  logic [ACC_W-1:0] dividend;
  logic [ACC_W-1:0] qacc;
  logic [NRM_W-1:0] dsr;
  logic [NRM_W-1:0] rem;
  logic             neg;
  logic [NRM_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem, dividend[ACC_W-1]};
  assign ge     = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= fin;
      fin  <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dividend <= num[ACC_W-1] ? -num : num;
      dsr      <= den[NRM_W-1] ? -den : den;
      neg      <= num[ACC_W-1] ^ den[NRM_W-1];
      rem      <= '0;
      qacc     <= '0;
      cnt      <= CNT_W'(ACC_W - 1);
    end else if (busy) begin
      rem      <= ge ? NRM_W'(rem_sh - {1'b0, dsr}) : rem_sh[NRM_W-1:0];
      qacc     <= {qacc[ACC_W-2:0], ge};
      dividend <= {dividend[ACC_W-2:0], 1'b0};
      cnt      <= cnt - 1'b1;
    end
    if (fin) begin
      quot <= neg ? -$signed(qacc) : $signed(qacc);
    end
  end

endmodule

FILE: rtl/core/tsg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsg_front: input acceptance, classification and command queue
// Tags each beat as load or query, checks the load index, and holds up to
// two commands for the back end.
// ----------------------------------------------------------------------------
module tsg_front
  import tsg_pkg::*;
#(
  parameter int STRIP_DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       mode,
  input  logic [IDX_W-1:0]           entry_index,
  input  logic signed [COORD_W-1:0]  coord_x,
  input  logic signed [COORD_W-1:0]  coord_y,
  input  logic signed [COORD_W-1:0]  coord_z,
  input  logic [RAD_W-1:0]           search_radius,
  output logic                       cmd_valid,
  output cmd_t                       cmd,
  input  logic                       cmd_pop
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  cmd_t       incoming;

  assign in_ready  = (fill != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = slots[rd_ptr];

  always_comb begin
    incoming.is_query = (mode == MODE_QUERY);
    incoming.in_range = ({22'd0, entry_index} < 32'(STRIP_DEPTH));
    incoming.index    = entry_index;
    incoming.x        = coord_x;
    incoming.y        = coord_y;
    incoming.z        = coord_z;
    incoming.radius   = search_radius;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, cmd_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill != 2'd3)
    else $error("command queue overfilled");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> fill != 2'd0)
    else $error("command popped from empty queue");

endmodule

FILE: rtl/core/tsg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsg_back: vertex store, triangle walker and result register
// Executes loads into the store and walks strip triangles for queries with
// one shared multiplier, an accumulator and a serial divider.
// ----------------------------------------------------------------------------
module tsg_back
  import tsg_pkg::*;
#(
  parameter int STRIP_DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [GRID_W-1:0]          grid_columns,
  input  logic [GRID_W-1:0]          grid_rows,
  input  logic                       cmd_valid,
  input  cmd_t                       cmd,
  output logic                       cmd_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       landed,
  output logic signed [COORD_W-1:0]  ground_y
);

  localparam int ADDR_W    = $clog2(STRIP_DEPTH);
  localparam int MAX_TRI   = STRIP_DEPTH - 2;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_OPS);

  state_t state, state_next;

  // Store ports.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [VTX_W-1:0]  ram_rdata;

  // Query context.
  logic signed [COORD_W-1:0] px, py, pz;
  logic [RAD_W-1:0]          radius;
  logic [ADDR_W-1:0]         tri_count;
  logic [ADDR_W-1:0]         tri_idx;
  logic [1:0]                rd_cnt;
  logic [STEP_W-1:0]         step;
  logic                      hit;
  logic                      odd;

  logic signed [COORD_W-1:0] vx [3];
  logic signed [COORD_W-1:0] vy [3];
  logic signed [COORD_W-1:0] vz [3];

  logic signed [DIFF_W-1:0] dx, dy, dz, o1x, o1z, o2x, o2z;
  logic signed [DIFF_W-1:0] e0x, e0y, e0z, e1x, e1z, e2x, e2z, mx, my, mz;
  logic [DIFF_W-1:0]        ax, ay, az;
  logic                     gate_fail;

  logic signed [NRM_W-1:0] nx, ny, nz;
  logic signed [ACC_W-1:0] num;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_next;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] base;
  logic signed [PROD_W-1:0] prod;
  op_t                      op_cur;
  op_t                      opq;
  logic                     opq_valid;
  logic                     chk_fail;
  logic signed [OPND_W-1:0] a_op, b_op;

  // Count of triangles from the grid registers.
  logic [15:0]       cells;
  logic [17:0]       cnt_raw;
  logic [17:0]       cnt_m4;
  logic [ADDR_W-1:0] count_cfg;

  // Divider and final height.
  logic                    div_start;
  logic                    div_done;
  logic signed [ACC_W-1:0] quot;
  logic signed [ACC_W:0]   hsum;
  logic signed [COORD_W-1:0] hsat;
  logic                    out_free;

  function automatic logic signed [DIFF_W-1:0] dif(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    return {a[COORD_W-1], a} - {b[COORD_W-1], b};
  endfunction

  function automatic logic [DIFF_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
    return v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
  endfunction

  function automatic logic signed [OPND_W-1:0] sx(input logic signed [DIFF_W-1:0] v);
    return {v[DIFF_W-1], v};
  endfunction

  function automatic logic signed [OPND_W-1:0] sel_opnd(input opnd_t s);
    logic signed [OPND_W-1:0] r;
    r = '0;
    unique case (s)
      OP_AX:   r = {1'b0, ax};
      OP_AY:   r = {1'b0, ay};
      OP_AZ:   r = {1'b0, az};
      OP_R:    r = {3'b000, radius};
      OP_DX:   r = sx(dx);
      OP_DY:   r = sx(dy);
      OP_DZ:   r = sx(dz);
      OP_E0X:  r = sx(e0x);
      OP_E0Y:  r = sx(e0y);
      OP_E0Z:  r = sx(e0z);
      OP_E1X:  r = sx(e1x);
      OP_E1Z:  r = sx(e1z);
      OP_E2X:  r = sx(e2x);
      OP_E2Z:  r = sx(e2z);
      OP_O1X:  r = sx(o1x);
      OP_O1Z:  r = sx(o1z);
      OP_O2X:  r = sx(o2x);
      OP_O2Z:  r = sx(o2z);
      OP_MX:   r = sx(mx);
      OP_MY:   r = sx(my);
      OP_MZ:   r = sx(mz);
      OP_NXL:  r = {1'b0, nx[HI_SHIFT-1:0]};
      OP_NXH:  r = nx[NRM_W-1:HI_SHIFT];
      OP_NYL:  r = {1'b0, ny[HI_SHIFT-1:0]};
      OP_NYH:  r = ny[NRM_W-1:HI_SHIFT];
      OP_NZL:  r = {1'b0, nz[HI_SHIFT-1:0]};
      OP_NZH:  r = nz[NRM_W-1:HI_SHIFT];
      default: r = '0;
    endcase
    return r;
  endfunction

  tsg_ram #(
    .WIDTH(VTX_W),
    .DEPTH(STRIP_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata({cmd.x, cmd.y, cmd.z}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  tsg_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (num),
    .den  (ny),
    .done (div_done),
    .quot (quot)
  );

  assign out_free  = !out_valid || out_ready;
  assign odd       = tri_idx[0];
  assign ram_waddr = ADDR_W'(cmd.index);

  // Triangle count, clamped to the triangles the store can hold.
  always_comb begin
    cells   = {8'd0, grid_columns} * {8'd0, grid_rows};
    cnt_raw = {1'b0, cells, 1'b0} + {8'd0, grid_rows, 2'b00};
    cnt_m4  = (cnt_raw < 18'd4) ? 18'd0 : cnt_raw - 18'd4;
    if ({14'd0, cnt_m4} > 32'(MAX_TRI)) begin
      count_cfg = ADDR_W'(MAX_TRI);
    end else begin
      count_cfg = ADDR_W'(cnt_m4);
    end
  end

  // Gate on the per-axis distance before any product is spent.
  always_comb begin
    ax = mag(dx);
    ay = mag(dy);
    az = mag(dz);
    gate_fail = (ax > {2'b00, radius}) || (ay > {2'b00, radius}) ||
                (az > {2'b00, radius});
  end

  always_comb begin
    op_cur = op_rom(step);
    a_op   = sel_opnd(op_cur.src_a);
    b_op   = sel_opnd(op_cur.src_b);
  end

  // Accumulator update and the check attached to the retiring product.
  always_comb begin
    term = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    if (opq.shift) begin
      term = term <<< HI_SHIFT;
    end
    base = (opq.acc == ACC_CLR) ? '0 : acc;
    acc_next = (opq.acc == ACC_SUB) ? base - term : base + term;
    unique case (opq.chk)
      CHK_GATE: chk_fail = !acc_next[ACC_W-1] && (acc_next != '0);
      CHK_EDGE: chk_fail = odd ? acc_next[ACC_W-1]
                               : (!acc_next[ACC_W-1] && (acc_next != '0));
      CHK_DOT:  chk_fail = !(acc_next[ACC_W-1] && (ny != '0));
      default:  chk_fail = 1'b0;
    endcase
  end

  // Height at the point, saturated to the coordinate range.
  always_comb begin
    hsum = {{(ACC_W+1-COORD_W){vy[0][COORD_W-1]}}, vy[0]} -
           {quot[ACC_W-1], quot};
    if (hsum[ACC_W:COORD_W-1] == '0 || hsum[ACC_W:COORD_W-1] == '1) begin
      hsat = hsum[COORD_W-1:0];
    end else if (hsum[ACC_W]) begin
      hsat = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      hsat = {1'b0, {(COORD_W-1){1'b1}}};
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid && cmd.is_query) begin
          state_next = S_START;
        end
      end
      S_START: begin
        state_next = (tri_count == '0) ? S_DONE : S_READ;
      end
      S_READ: begin
        if (rd_cnt == 2'd3) begin
          state_next = S_SETUP;
        end
      end
      S_SETUP: state_next = S_MAC;
      S_MAC: begin
        if (step == '0 && gate_fail) begin
          state_next = S_NEXT;
        end else if (opq_valid && chk_fail) begin
          state_next = S_NEXT;
        end else if (step == LAST_STEP) begin
          state_next = S_DIV;
        end
      end
      S_NEXT: begin
        state_next = (tri_idx + 1'b1 == tri_count) ? S_DONE : S_READ;
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    cmd_pop   = 1'b0;
    ram_we    = 1'b0;
    div_start = 1'b0;
    ram_raddr = ADDR_W'(tri_idx + {{(ADDR_W-2){1'b0}}, rd_cnt});
    unique case (state)
      S_IDLE: begin
        cmd_pop = cmd_valid && (cmd.is_query || out_free);
        ram_we  = cmd_valid && !cmd.is_query && cmd.in_range && out_free;
      end
      S_MAC: begin
        div_start = (step == LAST_STEP) && !(opq_valid && chk_fail);
      end
      default: begin
        cmd_pop = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      opq_valid <= 1'b0;
      hit       <= 1'b0;
    end else begin
      state     <= state_next;
      opq_valid <= (state == S_MAC) && (state_next == S_MAC);
      if (state == S_IDLE) begin
        hit <= 1'b0;
      end else if (state == S_DIV && div_done) begin
        hit <= 1'b1;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_IDLE && cmd_pop && !cmd.is_query) begin
        out_valid <= 1'b1;
      end else if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (cmd_pop) begin
          px        <= cmd.x;
          py        <= cmd.y;
          pz        <= cmd.z;
          radius    <= cmd.radius;
          tri_count <= count_cfg;
          // A query leaves a waiting result beat untouched.
          if (!cmd.is_query) begin
            landed   <= 1'b0;
            ground_y <= '0;
          end
        end
      end
      S_START: begin
        tri_idx <= '0;
        rd_cnt  <= 2'd0;
      end
      S_READ: begin
        rd_cnt <= rd_cnt + 1'b1;
        if (rd_cnt != 2'd0) begin
          vx[rd_cnt - 2'd1] <= ram_rdata[VTX_W-1:2*COORD_W];
          vy[rd_cnt - 2'd1] <= ram_rdata[2*COORD_W-1:COORD_W];
          vz[rd_cnt - 2'd1] <= ram_rdata[COORD_W-1:0];
        end
      end
      S_SETUP: begin
        step <= '0;
        dx   <= dif(px, vx[0]);
        dy   <= dif(py, vy[0]);
        dz   <= dif(pz, vz[0]);
        o1x  <= dif(px, vx[1]);
        o1z  <= dif(pz, vz[1]);
        o2x  <= dif(px, vx[2]);
        o2z  <= dif(pz, vz[2]);
        // Odd triangles wind the other way, so their edges rotate.
        if (!odd) begin
          e0x <= dif(vx[1], vx[0]);
          e0y <= dif(vy[1], vy[0]);
          e0z <= dif(vz[1], vz[0]);
          e1x <= dif(vx[2], vx[1]);
          e1z <= dif(vz[2], vz[1]);
          e2x <= dif(vx[0], vx[2]);
          e2z <= dif(vz[0], vz[2]);
          mx  <= dif(vx[2], vx[0]);
          my  <= dif(vy[2], vy[0]);
          mz  <= dif(vz[2], vz[0]);
        end else begin
          e0x <= dif(vx[0], vx[2]);
          e0y <= dif(vy[0], vy[2]);
          e0z <= dif(vz[0], vz[2]);
          e1x <= dif(vx[1], vx[0]);
          e1z <= dif(vz[1], vz[0]);
          e2x <= dif(vx[2], vx[1]);
          e2z <= dif(vz[2], vz[1]);
          mx  <= dif(vx[1], vx[2]);
          my  <= dif(vy[1], vy[2]);
          mz  <= dif(vz[1], vz[2]);
        end
      end
      S_MAC: begin
        step <= step + 1'b1;
        prod <= a_op * b_op;
        opq  <= op_cur;
        if (opq_valid) begin
          acc <= acc_next;
          unique case (opq.lat)
            LAT_NX:  nx  <= odd ? -acc_next[NRM_W-1:0] : acc_next[NRM_W-1:0];
            LAT_NY:  ny  <= odd ? -acc_next[NRM_W-1:0] : acc_next[NRM_W-1:0];
            LAT_NZ:  nz  <= odd ? -acc_next[NRM_W-1:0] : acc_next[NRM_W-1:0];
            LAT_NUM: num <= acc_next;
            default: begin
            end
          endcase
        end
      end
      S_NEXT: begin
        tri_idx <= tri_idx + 1'b1;
        rd_cnt  <= 2'd0;
      end
      S_DONE: begin
        if (out_free) begin
          landed   <= hit;
          ground_y <= hit ? hsat : py;
        end
      end
      default: begin
      end
    endcase
  end

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == S_IDLE)
    else $error("store written outside idle");
  a_tri_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MAC && step == '0) |-> tri_idx < tri_count)
    else $error("triangle index beyond count");
  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished while not awaited");

endmodule

FILE: tb/tsg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsg_checker: scoreboard for the terrain strip ground snap
// Watches the input, output and register ports, keeps its own copy of the
// strip store and the grid size, predicts each result beat and compares it.
// ----------------------------------------------------------------------------
module tsg_checker
  import tsg_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic                       cfg_index,
  input  logic [GRID_W-1:0]          cfg_data,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       mode,
  input  logic [IDX_W-1:0]           entry_index,
  input  logic signed [COORD_W-1:0]  coord_x,
  input  logic signed [COORD_W-1:0]  coord_y,
  input  logic signed [COORD_W-1:0]  coord_z,
  input  logic [RAD_W-1:0]           search_radius,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic                       landed,
  input  logic signed [COORD_W-1:0]  ground_y,
  output int                         failures,
  output int                         pending,
  output int                         landings
);

  typedef logic signed [159:0] wide_t;

  typedef struct {
    logic                      landed;
    logic signed [COORD_W-1:0] height;
  } snap_t;

  logic signed [COORD_W-1:0] store_x [1024];
  logic signed [COORD_W-1:0] store_y [1024];
  logic signed [COORD_W-1:0] store_z [1024];
  logic [GRID_W-1:0] cols_q, rows_q;
  snap_t snap_q[$];

  function automatic wide_t wabs(input wide_t v);
    return (v < 0) ? -v : v;
  endfunction

  // Point lies on the inner side of an edge, or on the edge itself.
  function automatic bit edge_inside(input wide_t ex, input wide_t ez, input wide_t ox,
                                     input wide_t oz, input bit odd);
    wide_t c;
    c = ex * oz - ox * ez;
    if (odd) c = -c;
    return c <= 0;
  endfunction

  function automatic snap_t ground_snap(input logic signed [COORD_W-1:0] px,
                                        input logic signed [COORD_W-1:0] py,
                                        input logic signed [COORD_W-1:0] pz,
                                        input logic [RAD_W-1:0] radius);
    snap_t res;
    int cnt;
    bit odd;
    wide_t x, y, z, r, ax, ay, az;
    wide_t v0x, v0y, v0z, v1x, v1y, v1z, v2x, v2y, v2z, dx, dy, dz;
    wide_t e0x, e0y, e0z, e1x, e1y, e1z, e2x, e2y, e2z, mx, my, mz;
    wide_t nx, ny, nz, dot, q, h;
    res.landed = 1'b0;
    res.height = py;
    x = px; y = py; z = pz; r = radius;
    cnt = 2 * int'(cols_q) * int'(rows_q) + 4 * int'(rows_q) - 4;
    if (cnt < 0) cnt = 0;
    if (cnt > 1022) cnt = 1022;
    for (int i = 0; i < cnt; i++) begin
      odd = i[0];
      v0x = store_x[i];   v0y = store_y[i];   v0z = store_z[i];
      v1x = store_x[i+1]; v1y = store_y[i+1]; v1z = store_z[i+1];
      v2x = store_x[i+2]; v2y = store_y[i+2]; v2z = store_z[i+2];
      dx = x - v0x; dy = y - v0y; dz = z - v0z;
      ax = wabs(dx); ay = wabs(dy); az = wabs(dz);
      if (ax > r || ay > r || az > r) continue;
      if (ax * ax + ay * ay + az * az > r * r) continue;
      if (!odd) begin
        e0x = v1x - v0x; e0y = v1y - v0y; e0z = v1z - v0z;
        e1x = v2x - v1x; e1y = v2y - v1y; e1z = v2z - v1z;
        e2x = v0x - v2x; e2y = v0y - v2y; e2z = v0z - v2z;
      end else begin
        e0x = v0x - v2x; e0y = v0y - v2y; e0z = v0z - v2z;
        e1x = v1x - v0x; e1y = v1y - v0y; e1z = v1z - v0z;
        e2x = v2x - v1x; e2y = v2y - v1y; e2z = v2z - v1z;
      end
      mx = -e2x; my = -e2y; mz = -e2z;
      nx = e0y * mz - e0z * my;
      ny = e0z * mx - e0x * mz;
      nz = e0x * my - e0y * mx;
      if (odd) begin
        nx = -nx; ny = -ny; nz = -nz;
      end
      if (!edge_inside(e0x, e0z, dx, dz, odd)) continue;
      if (!edge_inside(e1x, e1z, x - v1x, z - v1z, odd)) continue;
      if (!edge_inside(e2x, e2z, x - v2x, z - v2z, odd)) continue;
      dot = nx * dx + ny * dy + nz * dz;
      if (!(dot < 0) || ny == 0) continue;
      q = (nx * dx + nz * dz) / ny;
      h = v0y - q;
      if (h > 64'sd2147483647) res.height = 32'h7FFF_FFFF;
      else if (h < -64'sd2147483648) res.height = 32'h8000_0000;
      else res.height = h[31:0];
      res.landed = 1'b1;
      return res;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    snap_t want;
    if (rst) begin
      cols_q = 8'd1;
      rows_q = 8'd1;
      snap_q.delete();
      failures = 0;
      landings = 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_GRID_COLUMNS) cols_q = cfg_data;
        else if (cfg_index == REG_GRID_ROWS) rows_q = cfg_data;
      end
      if (in_valid && in_ready) begin
        if (mode == MODE_LOAD) begin
          store_x[entry_index] = coord_x;
          store_y[entry_index] = coord_y;
          store_z[entry_index] = coord_z;
          want.landed = 1'b0;
          want.height = '0;
        end else begin
          want = ground_snap(coord_x, coord_y, coord_z, search_radius);
        end
        snap_q = {snap_q, want};
      end
      if (out_valid && out_ready) begin
        if (snap_q.size() == 0) begin
          if (failures < 10) $display("[%0t] result beat with nothing expected", $realtime);
          failures++;
        end else begin
          want = snap_q.pop_front();
          if (want.landed) landings++;
          if (landed !== want.landed || ground_y !== want.height) begin
            if (failures < 10)
              $display("[%0t] mismatch: landed %0b/%0b ground_y %0d/%0d (exp/act)",
                       $realtime, want.landed, landed, want.height, ground_y);
            failures++;
          end
        end
      end
    end
    pending = snap_q.size();
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top level for the terrain strip ground snap testbench
// Loads short strips, runs a directed set of ground queries and then
// randomized phases over several grid sizes, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb;
  import tsg_pkg::*;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic                      cfg_index = REG_GRID_COLUMNS;
  logic [GRID_W-1:0]         cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      mode = MODE_LOAD;
  logic [IDX_W-1:0]          entry_index = '0;
  logic signed [COORD_W-1:0] coord_x = '0;
  logic signed [COORD_W-1:0] coord_y = '0;
  logic signed [COORD_W-1:0] coord_z = '0;
  logic [RAD_W-1:0]          search_radius = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      landed;
  logic signed [COORD_W-1:0] ground_y;
  int failures, pending, landings;

  // When set, neither side inserts gaps, so beats run back to back.
  bit steady = 1'b0;
  int n_loads = 0, n_queries = 0, n_settings = 0;

  localparam logic [RAD_W-1:0] RAD_MAX = {RAD_W{1'b1}};

  terrain_strip_ground_snap uut (.*);

  tsg_checker chk (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data, .in_valid, .in_ready, .mode,
    .entry_index, .coord_x, .coord_y, .coord_z, .search_radius, .out_valid,
    .out_ready, .landed, .ground_y, .failures, .pending, .landings
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // A fixed upper bound on the run; a hang in the walker ends up here.
  initial begin
    #20_000_000;
    $display("terrain_strip_ground_snap verification failed");
    $finish;
  end

  // Result side: each beat waits a random number of cycles before it is taken.
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Present one input beat and hold it until the block takes it. The task
  // returns in the time step of the accepting edge, so a following call with
  // no gap keeps valid high without driving it low in that step.
  task automatic send_beat(input logic m, input logic [IDX_W-1:0] idx,
                           input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y,
                           input logic signed [COORD_W-1:0] z,
                           input logic [RAD_W-1:0] r);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    mode <= m;
    entry_index <= idx;
    coord_x <= x;
    coord_y <= y;
    coord_z <= z;
    search_radius <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (m == MODE_LOAD) n_loads++;
    else n_queries++;
  endtask

  // Wait until every expected result has come back, then let the walker settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_grid(input logic [GRID_W-1:0] cols, input logic [GRID_W-1:0] rows);
    cfg_write <= 1'b1;
    cfg_index <= REG_GRID_COLUMNS;
    cfg_data <= cols;
    @(posedge clk);
    cfg_index <= REG_GRID_ROWS;
    cfg_data <= rows;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  function automatic int tri_count(input int cols, input int rows);
    int c;
    c = 2 * cols * rows + 4 * rows - 4;
    return (c > 1022) ? 1022 : c;
  endfunction

  // Vertex k of a regular strip: pairs of vertices step along x, alternating
  // between the two z rows. Flipping swaps the rows, which reverses winding.
  task automatic load_strip_vertex(input int k, input int s, input bit flip,
                                   input logic signed [COORD_W-1:0] y);
    send_beat(MODE_LOAD, k[IDX_W-1:0], (k >> 1) * s, y, (k[0] ^ flip) * s, '0);
  endtask

  // Query a point in or just beyond the footprint of the first cnt triangles.
  task automatic strip_query(input int cnt, input int s);
    int x, z, y;
    logic [RAD_W-1:0] r;
    x = $urandom_range(0, (cnt / 2 + 1) * s);
    z = $urandom_range(0, s);
    y = int'($urandom_range(0, 4 * s)) - 2 * s;
    r = ($urandom_range(0, 1) == 0) ? RAD_MAX : $urandom_range(s / 2, 3 * s);
    send_beat(MODE_QUERY, $urandom, x, y, z, r);
  endtask

  task automatic directed_set(input bit flip);
    int s;
    s = 32'h0001_0000;
    for (int k = 0; k < 4; k++) load_strip_vertex(k, s, flip, '0);
    // Above and below a flat patch, with the largest radius.
    send_beat(MODE_QUERY, '0, s / 4, s, s / 4, RAD_MAX);
    send_beat(MODE_QUERY, 10'h3FF, s / 4, -s, s / 4, RAD_MAX);
    send_beat(MODE_QUERY, '0, s + s / 4, -s, 3 * s / 4, RAD_MAX);
    // Exactly on a shared edge and on an outer edge.
    send_beat(MODE_QUERY, '0, s / 2, -s, s / 2, RAD_MAX);
    send_beat(MODE_QUERY, '0, s / 2, -1, 0, RAD_MAX);
    // Squared distance equal to the squared radius still passes the gate.
    send_beat(MODE_QUERY, '0, 0, -s, 0, s);
    send_beat(MODE_QUERY, '0, s / 8, -s / 8, 0, 0);
    // Coordinate extremes with the radius at both ends.
    send_beat(MODE_QUERY, '0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, RAD_MAX);
    send_beat(MODE_QUERY, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0);
  endtask

  initial begin
    int cnt, s, pick, gc, gr;
    bit flip;
    int cols_list[10] = '{255, 3, 255, 1, 2, 4, 1, 4, 2, 3};
    int rows_list[10] = '{255, 2, 1, 255, 3, 3, 2, 1, 2, 1};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_grid(8'd1, 8'd1);

    // Directed part over one cell: both windings, edges, the gate boundary.
    directed_set(1'b0);
    directed_set(1'b1);
    // A triangle standing on edge has a zero normal y and counts as a miss.
    send_beat(MODE_LOAD, 10'd0, 0, 0, 0, '0);
    send_beat(MODE_LOAD, 10'd1, 32'h0001_0000, 32'h0001_0000, 0, '0);
    send_beat(MODE_LOAD, 10'd2, 32'h0001_0000, -32'sh0001_0000, 0, '0);
    send_beat(MODE_QUERY, '0, 32'h0000_8000, -32'sh0000_4000, 0, RAD_MAX);
    send_beat(MODE_LOAD, 10'h3FF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '0);
    send_beat(MODE_LOAD, 10'h3FF, 32'h0100_0000, 32'h7FFF_FFFF, 32'h0000_0000, '0);
    drain();

    // Random phases. The first entry of the list is the largest grid, which
    // saturates the triangle count; large grids only get a few queries.
    for (int ph = 0; ph < 11; ph++) begin
      gc = (ph < 10) ? cols_list[ph] : $urandom_range(1, 3);
      gr = (ph < 10) ? rows_list[ph] : $urandom_range(1, 3);
      set_grid(GRID_W'(gc), GRID_W'(gr));
      cnt = tri_count(gc, gr);
      steady = ($urandom_range(0, 3) == 0);
      if (cnt > 40) begin
        // Only the first cells are loaded; each point sits far below them in
        // their footprint, so the walk lands before leaving loaded entries.
        s = 32'h0001_0000;
        for (int k = 0; k < 8; k++)
          load_strip_vertex(k, s, 1'b0, int'($urandom_range(0, 2 * s)) - s);
        for (int n = 0; n < 3; n++)
          send_beat(MODE_QUERY, $urandom, $urandom_range(0, 2 * s), -8 * s,
                    $urandom_range(0, s), RAD_MAX);
      end else begin
        s = 1 << $urandom_range(8, 20);
        flip = $urandom_range(0, 1);
        for (int k = 0; k < cnt + 2; k++)
          load_strip_vertex(k, s, flip, int'($urandom_range(0, 2 * s)) - s);
        for (int n = 0; n < 12; n++) begin
          pick = $urandom_range(0, 19);
          if (pick < 14) strip_query(cnt, s);
          else if (pick < 16)
            send_beat(MODE_LOAD, $urandom_range(0, cnt + 1), $urandom, $urandom,
                      $urandom, $urandom);
          else
            send_beat(MODE_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
      end
      // The sender holds off here until every result has come back.
      drain();
    end

    $display("covered %0d loads and %0d ground queries (%0d landings) over %0d grid settings",
             n_loads, n_queries, landings, n_settings);
    if (failures == 0) begin
      $display("terrain_strip_ground_snap verification clean");
    end else begin
      $display("%0d mismatches", failures);
      $display("terrain_strip_ground_snap verification failed");
    end
    $finish;
  end

endmodule

FILE: terrain_strip_ground_snap.f
rtl/core/tsg_pkg.sv
rtl/core/tsg_ram.sv
rtl/core/tsg_div.sv
rtl/core/tsg_front.sv
rtl/core/tsg_back.sv
rtl/core/terrain_strip_ground_snap.sv
tb/tsg_checker.sv
tb/tb.sv
